>>> src/dfe_pkg.sv
package dfe_pkg;

  // field widths
  localparam int unsigned WordW       = 32;
  localparam int unsigned PosW        = 24;
  localparam int unsigned MawCntW     = 16;
  localparam int unsigned HdrW        = 5;
  localparam int unsigned WaveTotW    = 26;
  localparam int unsigned IdxW        = 27;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned StampW      = 48;
  localparam int unsigned CfgIndexW   = 8;
  localparam int unsigned CfgDataW    = 24;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_EVENT_WORDS = 8'd0,
    CFG_MAW_WORDS   = 8'd1
  } cfg_reg_e;

  // reset and start values
  localparam logic [PosW-1:0]    EventWordsRst = 24'd3;
  localparam logic [PosW-1:0]    MinEventWords = 24'd3;
  localparam logic [HdrW-1:0]    HdrBaseWords  = 5'd3;
  localparam logic [HdrW-1:0]    HdrAddFmt0    = 5'd7;
  localparam logic [HdrW-1:0]    HdrAddFmt1    = 5'd2;
  localparam logic [HdrW-1:0]    HdrAddFmt2    = 5'd3;
  localparam logic [HdrW-1:0]    HdrAddFmt3    = 5'd2;
  localparam logic [SampleW-1:0] FloorStart    = 16'd16384;
  localparam logic [WordW-1:0]   MawOffset     = 32'h0800_0000;
  localparam logic [WordW-1:0]   MawFloorStart = 32'h7fff_ffff;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]          pad;
    logic signed [31:0]  maw_floor;
    logic [30:0]         maw_peak;
    logic [SampleW-1:0]  wave_floor;
    logic [IdxW-1:0]     wave_peak_index;
    logic [SampleW-1:0]  wave_peak;
    logic [IdxW-1:0]     sample_count;
    logic [StampW-1:0]   event_timestamp;
    logic [3:0]          header_format;
    logic [11:0]         channel_id;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

>>> src/digitizer_event_feature_extractor_unit.sv
// Digitizer event feature extractor.
// Input stream s_axis_*: one 32-bit event buffer word per transfer. Every event
// is event_words words long (values below 3 act as 3); it opens with a header
// (format, channel, timestamp, waveform word count), then waveform words of two
// 16-bit samples, then maw_words moving-average words.
// Output stream m_axis_*: one summary word on the last word of each event, with
// channel, format, timestamp, sample count, waveform peak/index/floor and the
// offset-corrected MAW peak and floor.
// Configuration channel cfg_*: index 0 = event_words, 1 = maw_words; always
// ready, other indexes are ignored. Write only while the block is idle.
// Throughput: one word per cycle while the output register can take a summary;
// every word is folded into the trackers in the cycle it is accepted. The summary
// is registered and sits in the output register the cycle after the last word.
// A stalled receiver holds the summary in the output register; input words are
// still taken as long as that register is empty or drains in the same cycle.
// Reset clears the word counter and the trackers and restores event_words = 3,
// maw_words = 0; the block is ready on the first cycle after reset.
module digitizer_event_feature_extractor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dfe_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [dfe_pkg::CfgDataW-1:0]       cfg_data_i,
  // input words
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [dfe_pkg::WordW-1:0]          s_axis_tdata_i,   // data_word
  // summary words
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // channel_id, header_format, event_timestamp, sample_count, wave_peak,
  // wave_peak_index, wave_floor, maw_peak, maw_floor, 3 zero bits
  output logic [dfe_pkg::ResultW-1:0]        m_axis_tdata_o
);
  import dfe_pkg::*;

  // configuration registers
  logic [PosW-1:0]    event_words_q;
  logic [MawCntW-1:0] maw_words_q;

  // event state
  logic [PosW-1:0]     pos_q, pos_d;
  logic [3:0]          fmt_q, fmt_d;
  logic [HdrW-1:0]     hdr_q, hdr_d;
  logic [11:0]         chan_q, chan_d;
  logic [StampW-1:0]   stamp_q, stamp_d;
  logic [WaveTotW-1:0] total_q, total_d;
  logic [SampleW-1:0]  peak_q, peak_d;
  logic [IdxW-1:0]     peak_idx_q, peak_idx_d;
  logic [SampleW-1:0]  floor_q, floor_d;
  logic [WordW-1:0]    maw_pk_q, maw_pk_d;
  logic [WordW-1:0]    maw_fl_q, maw_fl_d;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic                in_fire;
  logic                first_word;
  logic                count_word;
  logic                last_word;
  logic                in_wave;
  logic                in_maw;
  logic [WordW-1:0]    w;
  logic [PosW-1:0]     len;
  logic [HdrW-1:0]     hdr_new;
  logic [IdxW-1:0]     wave_end;
  logic [IdxW:0]       maw_end;
  logic [PosW-1:0]     wave_off;
  logic [IdxW-1:0]     idx0;
  logic [IdxW-1:0]     idx1;
  logic [SampleW-1:0]  s0, s1;
  logic [SampleW-1:0]  peak_b, peak_m, floor_b, floor_m;
  logic [IdxW-1:0]     idx_b, idx_m;
  logic [WordW-1:0]    mpk_b, mfl_b, maw_val;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign w               = s_axis_tdata_i;

  // header length from the format flags of word 0
  assign hdr_new = HdrBaseWords
                 + (w[0] ? HdrAddFmt0 : '0)
                 + (w[1] ? HdrAddFmt1 : '0)
                 + (w[2] ? HdrAddFmt2 : '0)
                 + (w[3] ? HdrAddFmt3 : '0);

  assign first_word = (pos_q == '0);
  assign len        = (event_words_q < MinEventWords) ? MinEventWords : event_words_q;
  assign last_word  = (pos_q >= len - 1'b1);

  // header fields, refreshed on word 0 (low timestamp bits on word 1)
  always_comb begin
    fmt_d   = fmt_q;
    hdr_d   = hdr_q;
    chan_d  = chan_q;
    stamp_d = stamp_q;
    if (first_word) begin
      fmt_d   = w[3:0];
      hdr_d   = hdr_new;
      chan_d  = w[15:4];
      stamp_d = {w[31:16], 32'd0};
    end else if (pos_q == PosW'(1)) begin
      stamp_d = {stamp_q[StampW-1:32], w};
    end
  end

  // tracker start values for this word
  always_comb begin
    if (first_word) begin
      peak_b  = '0;
      idx_b   = '0;
      floor_b = FloorStart;
      mpk_b   = '0;
      mfl_b   = MawFloorStart;
    end else begin
      peak_b  = peak_q;
      idx_b   = peak_idx_q;
      floor_b = floor_q;
      mpk_b   = maw_pk_q;
      mfl_b   = maw_fl_q;
    end
  end

  // region decode, word 0 always belongs to the header
  assign count_word = !first_word && (pos_q == PosW'(hdr_q) - 1'b1);
  assign wave_end   = IdxW'(hdr_q) + IdxW'(total_q);
  assign maw_end    = (IdxW+1)'(wave_end) + (IdxW+1)'(maw_words_q);
  assign in_wave    = !first_word && !count_word && (pos_q >= PosW'(hdr_q))
                      && (IdxW'(pos_q) < wave_end);
  assign in_maw     = !first_word && !count_word && !in_wave
                      && (IdxW'(pos_q) >= wave_end)
                      && ((IdxW+1)'(pos_q) < maw_end);

  // waveform samples, low half first
  assign wave_off = pos_q - PosW'(hdr_q);
  assign idx0     = {2'b00, wave_off, 1'b0};
  assign idx1     = {2'b00, wave_off, 1'b1};
  assign s0       = w[15:0];
  assign s1       = w[31:16];

  always_comb begin
    peak_m  = peak_b;
    idx_m   = idx_b;
    floor_m = floor_b;
    if (s0 > peak_m) begin
      peak_m = s0;
      idx_m  = idx0;
    end
    if (s0 < floor_m) begin
      floor_m = s0;
    end
  end

  assign maw_val = w - MawOffset;

  always_comb begin
    total_d    = first_word ? '0 : total_q;
    peak_d     = peak_b;
    peak_idx_d = idx_b;
    floor_d    = floor_b;
    maw_pk_d   = mpk_b;
    maw_fl_d   = mfl_b;
    if (count_word) begin
      total_d = w[WaveTotW-1:0];
    end else if (in_wave) begin
      peak_d     = peak_m;
      peak_idx_d = idx_m;
      floor_d    = floor_m;
      if (s1 > peak_m) begin
        peak_d     = s1;
        peak_idx_d = idx1;
      end
      if (s1 < floor_m) begin
        floor_d = s1;
      end
    end else if (in_maw) begin
      if ($signed(maw_val) > $signed(mpk_b)) begin
        maw_pk_d = maw_val;
      end
      if ($signed(maw_val) < $signed(mfl_b)) begin
        maw_fl_d = maw_val;
      end
    end
  end

  assign pos_d = last_word ? '0 : pos_q + 1'b1;

  // summary word
  always_comb begin
    out_d                 = out_q;
    out_valid_d           = out_valid_q && !m_axis_tready_i;
    if (in_fire && last_word) begin
      out_valid_d           = 1'b1;
      out_d.pad             = '0;
      out_d.channel_id      = chan_d;
      out_d.header_format   = fmt_d;
      out_d.event_timestamp = stamp_d;
      out_d.sample_count    = {total_d, 1'b0};
      out_d.wave_peak       = peak_d;
      out_d.wave_peak_index = peak_idx_d;
      out_d.wave_floor      = floor_d;
      out_d.maw_peak        = maw_pk_d[30:0];
      out_d.maw_floor       = maw_fl_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_words_q <= EventWordsRst;
      maw_words_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_EVENT_WORDS: event_words_q <= cfg_data_i[PosW-1:0];
        CFG_MAW_WORDS:   maw_words_q   <= cfg_data_i[MawCntW-1:0];
        default: ;
      endcase
    end
  end

  // event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      fmt_q      <= '0;
      hdr_q      <= HdrBaseWords;
      chan_q     <= '0;
      stamp_q    <= '0;
      total_q    <= '0;
      peak_q     <= '0;
      peak_idx_q <= '0;
      floor_q    <= FloorStart;
      maw_pk_q   <= '0;
      maw_fl_q   <= MawFloorStart;
    end else if (in_fire) begin
      pos_q      <= pos_d;
      fmt_q      <= fmt_d;
      hdr_q      <= hdr_d;
      chan_q     <= chan_d;
      stamp_q    <= stamp_d;
      total_q    <= total_d;
      peak_q     <= peak_d;
      peak_idx_q <= peak_idx_d;
      floor_q    <= floor_d;
      maw_pk_q   <= maw_pk_d;
      maw_fl_q   <= maw_fl_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
